### hdl/stit_pkg.sv
// Shared types and constants for the sorted time index table.
package stit_pkg;

    localparam int TIME_W  = 32;
    localparam int COUNT_W = 7;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 80;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_FIND   = 1'b1;

    typedef struct packed {
        logic              hit;
        logic [TIME_W-1:0] match_time;
        logic [TIME_W-1:0] last_time;
    } leaf_t;

endpackage

### hdl/stit_cell.sv
// One entry of the descending time table with its insert and search logic.
module stit_cell (
    input  logic                          aclk,
    input  logic                          insert_en,
    input  logic                          capture_en,
    input  logic                          valid,
    input  logic                          drop,
    input  logic                          next_valid,
    input  logic                          prev_gt,
    input  logic                          prev_flag,
    input  logic [stit_pkg::TIME_W-1:0]   prev_value,
    input  logic [stit_pkg::TIME_W-1:0]   key,
    output logic [stit_pkg::TIME_W-1:0]   value,
    output logic                          gt,
    output logic                          flag,
    output stit_pkg::leaf_t               leaf
);

    logic [stit_pkg::TIME_W-1:0] value_reg;
    logic [stit_pkg::TIME_W-1:0] value_next;
    stit_pkg::leaf_t             leaf_reg;
    stit_pkg::leaf_t             leaf_next;

    assign value = value_reg;
    assign gt    = valid && (value_reg > key);
    assign flag  = valid && !gt;
    assign leaf  = leaf_reg;

    // An entry above the key stays unless drop is set; otherwise it takes the key or its neighbor's entry.
    always_comb begin
        if (gt && !drop) begin
            value_next = value_reg;
        end else if (prev_gt) begin
            value_next = key;
        end else begin
            value_next = prev_value;
        end
    end

    always_comb begin
        leaf_next.hit        = flag && !prev_flag;
        leaf_next.match_time = (flag && !prev_flag) ? value_reg : '0;
        leaf_next.last_time  = (valid && !next_valid) ? value_reg : '0;
    end

    always_ff @(posedge aclk) begin
        if (insert_en) begin
            value_reg <= value_next;
        end
        if (capture_en) begin
            leaf_reg <= leaf_next;
        end
    end

endmodule

### hdl/stit_tree.sv
// Registered OR tree that merges the per-entry search results.
module stit_tree #(
    parameter int LEAVES = 64
) (
    input  logic            aclk,
    input  stit_pkg::leaf_t leaf_in [LEAVES],
    output stit_pkg::leaf_t root
);

    localparam int LVL   = (LEAVES > 1) ? $clog2(LEAVES) : 0;
    localparam int SLOTS = 1 << LVL;

    if (SLOTS == 1) begin : g_single
        assign root = leaf_in[0];
    end else begin : g_tree
        stit_pkg::leaf_t node_w   [2*SLOTS-1];
        stit_pkg::leaf_t tree_reg [SLOTS-1];

        for (genvar n = 0; n < SLOTS - 1; n++) begin : g_node
            assign node_w[n] = tree_reg[n];
            always_ff @(posedge aclk) begin
                tree_reg[n] <= node_w[2*n+1] | node_w[2*n+2];
            end
        end

        for (genvar k = 0; k < SLOTS; k++) begin : g_leaf
            if (k < LEAVES) begin : g_used
                assign node_w[SLOTS-1+k] = leaf_in[k];
            end else begin : g_pad
                assign node_w[SLOTS-1+k] = '0;
            end
        end

        assign root = node_w[0];
    end

endmodule

### hdl/sorted_time_index_table_top.sv
// Top level of the sorted time index table: cell row, search tree and stream control.
//
//  Channel | Direction | tdata (low bit up)                         | tuser
//  s_axis  | in        | time_value[31:0]                           | cmd
//  m_axis  | out       | entry_count, evicted_valid, evicted_time,  | -
//          |           | found, match_time, zero fill to 80 bits    |
//
// An insert shifts the whole cell row in the cycle it is accepted; its result is
// registered on that same edge. A find captures every cell's compare result on the
// accept edge and then runs through the OR tree, log2(CAPACITY) register levels,
// before its result is registered into the output.
// One transaction is in flight at a time. Reset empties the table at once; no sweep.
// While a result waits on m_axis, no new transaction is accepted.
module sorted_time_index_table_top #(
    parameter int CAPACITY = 64
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [stit_pkg::S_TDATA_W-1:0]     s_axis_tdata,  // time_value[31:0]
    input  logic                               s_axis_tuser,  // cmd
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // entry_count[6:0], evicted_valid[7], evicted_time[39:8], found[40],
    // match_time[72:41], zero [79:73]
    output logic [stit_pkg::M_TDATA_W-1:0]     m_axis_tdata
);

    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int TREE_LVL = (CAPACITY > 1) ? $clog2(CAPACITY) : 0;
    localparam int LAT_W    = (TREE_LVL > 0) ? $clog2(TREE_LVL + 1) : 1;
    localparam int TW       = stit_pkg::TIME_W;
    localparam logic [TW-1:0] TIME_ZERO = '0;

    typedef enum logic {
        ST_IDLE,
        ST_SEARCH
    } state_t;

    state_t                            state_reg;
    logic [CNT_W-1:0]                  count_reg;
    logic [LAT_W-1:0]                  lat_reg;
    logic                              miss_reg;
    logic                              m_valid_reg;
    logic [stit_pkg::M_TDATA_W-1:0]    m_data_reg;

    logic                              accept;
    logic                              insert_en;
    logic                              capture_en;
    logic                              full;
    logic                              out_taken;
    logic                              result_set;
    logic [TW-1:0]                     key;

    logic [TW-1:0]                     cell_value [CAPACITY];
    logic                              cell_gt    [CAPACITY];
    logic                              cell_flag  [CAPACITY];
    logic                              cell_valid [CAPACITY];
    stit_pkg::leaf_t                   cell_leaf  [CAPACITY];
    stit_pkg::leaf_t                   root;

    assign key           = s_axis_tdata[TW-1:0];
    assign s_axis_tready = (state_reg == ST_IDLE) && (!m_valid_reg || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign insert_en     = accept && (s_axis_tuser == stit_pkg::CMD_INSERT);
    assign capture_en    = accept && (s_axis_tuser == stit_pkg::CMD_FIND);
    assign full          = (count_reg == CNT_W'(CAPACITY));
    assign out_taken     = m_valid_reg && m_axis_tready;
    assign result_set    = insert_en || ((state_reg == ST_SEARCH) && (lat_reg == '0));

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic prev_gt;
        logic prev_flag;
        logic next_valid;
        logic drop;
        logic [TW-1:0] prev_value;

        assign cell_valid[i] = (CNT_W'(i) < count_reg);

        if (i == 0) begin : g_first
            assign prev_gt    = 1'b1;
            assign prev_flag  = 1'b0;
            assign prev_value = key;
        end else begin : g_inner
            assign prev_gt    = cell_gt[i-1];
            assign prev_flag  = cell_flag[i-1];
            assign prev_value = cell_value[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign next_valid = 1'b0;
            assign drop       = full;
        end else begin : g_mid
            assign next_valid = cell_valid[i+1];
            assign drop       = 1'b0;
        end

        stit_cell u_cell (
            .aclk       (aclk),
            .insert_en  (insert_en),
            .capture_en (capture_en),
            .valid      (cell_valid[i]),
            .drop       (drop),
            .next_valid (next_valid),
            .prev_gt    (prev_gt),
            .prev_flag  (prev_flag),
            .prev_value (prev_value),
            .key        (key),
            .value      (cell_value[i]),
            .gt         (cell_gt[i]),
            .flag       (cell_flag[i]),
            .leaf       (cell_leaf[i])
        );
    end

    stit_tree #(
        .LEAVES (CAPACITY)
    ) u_tree (
        .aclk    (aclk),
        .leaf_in (cell_leaf),
        .root    (root)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            lat_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (result_set) begin
                m_valid_reg <= 1'b1;
            end else if (out_taken) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (insert_en) begin
                        count_reg  <= full ? count_reg : count_reg + CNT_W'(1);
                        m_data_reg <= {7'd0, TIME_ZERO, 1'b0,
                                       full ? cell_value[CAPACITY-1] : TIME_ZERO, full,
                                       full ? 7'(count_reg) : 7'(count_reg + CNT_W'(1))};
                    end else if (capture_en) begin
                        // A query above the newest entry, or an empty table, is a miss.
                        miss_reg  <= !cell_valid[0] || (cell_value[0] < key);
                        lat_reg   <= LAT_W'(TREE_LVL);
                        state_reg <= ST_SEARCH;
                    end
                end
                ST_SEARCH: begin
                    if (lat_reg == '0) begin
                        m_data_reg <= {7'd0,
                                       miss_reg ? TIME_ZERO :
                                           (root.hit ? root.match_time : root.last_time),
                                       !miss_reg, TIME_ZERO, 1'b0, 7'(count_reg)};
                        state_reg  <= ST_IDLE;
                    end else begin
                        lat_reg <= lat_reg - LAT_W'(1);
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

### hdl/stit_checker.sv
// Port-level checks for the sorted time index table and their binding.
module stit_checker #(
    parameter int CAPACITY = 64
) (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic [stit_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    input logic                               s_axis_tuser,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [stit_pkg::M_TDATA_W-1:0]     m_axis_tdata
);

    localparam logic [6:0] FULL_COUNT = 7'(CAPACITY);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("Result transaction changed while stalled.");

    a_no_accept_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("Input accepted while a result is stalled.");

    a_evict_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[7] |->
            !m_axis_tdata[40] && (m_axis_tdata[6:0] == FULL_COUNT))
        else $error("Eviction reported without a full table.");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tdata[40] |-> (m_axis_tdata[72:41] == '0))
        else $error("Match time nonzero on a miss.");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("Result valid right after reset.");

endmodule

bind sorted_time_index_table_top stit_checker #(.CAPACITY(CAPACITY)) u_stit_checker (.*);
